>>> hdl/trie_insert_search_prefix_top_assert.svh
// Assertion macros shared by the trie block modules
`ifndef TRIE_INSERT_SEARCH_PREFIX_TOP_ASSERT_SVH
`define TRIE_INSERT_SEARCH_PREFIX_TOP_ASSERT_SVH
// same-cycle implication
`define TISP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tisp assertion failed");
// next-cycle implication
`define TISP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tisp assertion failed");
`endif

>>> hdl/tisp_pkg.sv
// Shared types and constants for the trie insert/search block
package tisp_pkg;

	localparam int NODES_DEF    = 1024;
	localparam int ALPHABET_DEF = 26;
	localparam int LETTER_W     = 5;

	typedef logic [1:0] op_t;
	localparam op_t OP_INSERT = 2'd0;
	localparam op_t OP_SEARCH = 2'd1;
	localparam op_t OP_PREFIX = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_FINISH,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic clear;
		logic take;
		logic walk;
		logic finish;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic last;
		logic out_free;
	} ctrl_sts_t;

endpackage

>>> hdl/tisp_ram.sv
// Generic simple dual-port RAM with registered read
module tisp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> hdl/tisp_ctrl.sv
// Controller state machine for the trie block
`include "trie_insert_search_prefix_top_assert.svh"
module tisp_ctrl import tisp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  ctrl_sts_t sts,
	output ctrl_cmd_t ctl
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_LOOK;
			end
			ST_LOOK: begin
				state_d = sts.last ? ST_FINISH : ST_IDLE;
			end
			ST_FINISH: begin
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		ctl      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ctl.clear = 1'b1;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				ctl.take = in_valid;
			end
			ST_LOOK: begin
				ctl.walk = 1'b1;
			end
			ST_FINISH: begin
				ctl.finish = 1'b1;
			end
			ST_RESULT: begin
				ctl.emit = sts.out_free;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	`TISP_ASSERT_NEXT(a_take_look, clk, arst_n, ctl.take, state_q == ST_LOOK)
	`TISP_ASSERT_NEXT(a_look_exit, clk, arst_n, state_q == ST_LOOK,
		state_q == ST_IDLE || state_q == ST_FINISH)
	`TISP_ASSERT_NEXT(a_result_hold, clk, arst_n, state_q == ST_RESULT && !sts.out_free,
		state_q == ST_RESULT)

endmodule

>>> hdl/tisp_dpath.sv
// Datapath of the trie block: node memories, walk registers, result register
`include "trie_insert_search_prefix_top_assert.svh"
module tisp_dpath import tisp_pkg::*; #(
	parameter int NODES    = NODES_DEF,
	parameter int ALPHABET = ALPHABET_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ctrl_cmd_t           ctl,
	output ctrl_sts_t           sts,
	input  op_t                 cmd,
	input  logic [LETTER_W-1:0] letter,
	input  logic                letter_valid,
	input  logic                last,
	input  logic                out_ready,
	output logic                out_valid,
	output logic                found,
	output logic                status
);

	localparam int NW = $clog2(NODES);
	localparam int RW = ALPHABET * NW;
	localparam int FW = NW + 1;
	localparam int XW = 9;

	logic [NW-1:0]       clr_q;
	logic [NW-1:0]       cursor_q;
	logic [FW-1:0]       next_free_q;
	op_t                 active_cmd_q;
	logic                missing_q;
	logic                overflow_q;
	logic                in_word_q;
	logic [LETTER_W-1:0] letter_q;
	logic                letter_valid_q;
	logic                last_q;
	logic                out_valid_q;
	logic                found_q;
	logic                status_q;

	logic [RW-1:0] row_rd;
	logic [RW-1:0] row_new;
	logic [RW-1:0] row_wdata;
	logic          row_we;
	logic [NW-1:0] row_waddr;
	logic [NW-1:0] row_raddr;
	logic          mark_rd;
	logic          mark_we;
	logic [NW-1:0] mark_waddr;
	logic          mark_wdata;

	logic [NW-1:0] child;
	logic          child_ok;
	logic          letter_bad;
	logic          pool_ok;
	logic          walk_go;
	logic          grow;
	logic          res_found;
	logic          res_status;

	// pick the child slot and build the updated row for an insert
	always_comb begin
		child   = '0;
		row_new = row_rd;
		for (int i = 0; i < ALPHABET; i++) begin
			if ({{(XW-LETTER_W){1'b0}}, letter_q} == XW'(i)) begin
				child               = row_rd[i*NW +: NW];
				row_new[i*NW +: NW] = next_free_q[NW-1:0];
			end
		end
	end

	assign letter_bad = {{(XW-LETTER_W){1'b0}}, letter_q} >= XW'(ALPHABET);
	assign child_ok   = (child != '0) && (FW'(child) < FW'(NODES));
	assign pool_ok    = next_free_q < FW'(NODES);
	assign walk_go    = letter_valid_q && !missing_q && !overflow_q;
	assign grow       = ctl.walk && walk_go && !letter_bad && !child_ok &&
		(active_cmd_q == OP_INSERT) && pool_ok;

	always_comb begin
		row_we    = 1'b0;
		row_waddr = cursor_q;
		row_wdata = row_new;
		if (ctl.clear) begin
			row_we    = 1'b1;
			row_waddr = clr_q;
			row_wdata = '0;
		end else if (grow) begin
			row_we = 1'b1;
		end
	end

	always_comb begin
		mark_we    = 1'b0;
		mark_waddr = cursor_q;
		mark_wdata = 1'b1;
		if (ctl.clear) begin
			mark_we    = 1'b1;
			mark_waddr = clr_q;
			mark_wdata = 1'b0;
		end else if (ctl.finish && active_cmd_q == OP_INSERT && !overflow_q && !missing_q) begin
			mark_we = 1'b1;
		end
	end

	// a new word starts its walk at the root
	assign row_raddr = in_word_q ? cursor_q : '0;

	tisp_ram #(
		.WIDTH (RW),
		.DEPTH (NODES)
	) u_rows (
		.clk     (clk),
		.wr_en   (row_we),
		.wr_addr (row_waddr),
		.wr_data (row_wdata),
		.rd_en   (ctl.take),
		.rd_addr (row_raddr),
		.rd_data (row_rd)
	);

	tisp_ram #(
		.WIDTH (1),
		.DEPTH (NODES)
	) u_marks (
		.clk     (clk),
		.wr_en   (mark_we),
		.wr_addr (mark_waddr),
		.wr_data (mark_wdata),
		.rd_en   (ctl.finish),
		.rd_addr (cursor_q),
		.rd_data (mark_rd)
	);

	always_comb begin
		res_found  = 1'b0;
		res_status = 1'b0;
		case (active_cmd_q)
			OP_INSERT: begin
				res_status = overflow_q;
				res_found  = !overflow_q && !missing_q;
			end
			OP_PREFIX: begin
				res_found = !missing_q;
			end
			default: begin
				res_found = !missing_q && mark_rd;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q        <= '0;
			cursor_q     <= '0;
			next_free_q  <= FW'(1);
			active_cmd_q <= OP_INSERT;
			missing_q    <= 1'b0;
			overflow_q   <= 1'b0;
			in_word_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (ctl.clear) begin
				clr_q <= clr_q + NW'(1);
			end
			if (ctl.take && !in_word_q) begin
				active_cmd_q <= cmd;
				cursor_q     <= '0;
				missing_q    <= 1'b0;
				overflow_q   <= 1'b0;
				in_word_q    <= 1'b1;
			end
			if (ctl.walk && walk_go) begin
				if (letter_bad) begin
					missing_q <= 1'b1;
				end else if (child_ok) begin
					cursor_q <= child;
				end else if (active_cmd_q != OP_INSERT) begin
					missing_q <= 1'b1;
				end else if (pool_ok) begin
					cursor_q    <= next_free_q[NW-1:0];
					next_free_q <= next_free_q + FW'(1);
				end else begin
					overflow_q <= 1'b1;
				end
			end
			if (ctl.emit) begin
				out_valid_q <= 1'b1;
				in_word_q   <= 1'b0;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers: hold the item and the result
	always_ff @(posedge clk) begin
		if (ctl.take) begin
			letter_q       <= letter;
			letter_valid_q <= letter_valid;
			last_q         <= last;
		end
		if (ctl.emit) begin
			found_q  <= res_found;
			status_q <= res_status;
		end
	end

	assign sts.clr_last = (clr_q == NW'(NODES - 1));
	assign sts.last     = last_q;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign status    = status_q;

	`TISP_ASSERT_NOW(a_free_bound, clk, arst_n, 1'b1, next_free_q <= FW'(NODES))
	`TISP_ASSERT_NOW(a_cursor_alloc, clk, arst_n, 1'b1, FW'(cursor_q) < next_free_q)
	`TISP_ASSERT_NEXT(a_overflow_hold, clk, arst_n, ctl.walk && overflow_q, $stable(cursor_q))

endmodule

>>> hdl/trie_insert_search_prefix_top.sv
// Top level of the trie insert / exact search / prefix search block
//
// channel | dir | handshake           | fields
// in      | in  | in_valid, in_ready   | cmd, letter, letter_valid, last
// out     | out | out_valid, out_ready | found, status
//
// Each item is taken with a registered read of the node's child row, then the walk step
// with an optional row write on insert. The last item of a word then adds the word-end
// mark read or write and the result load.
// After reset a clearing sweep writes every node row and mark with in_ready low.
// A result waits in the output register while the next items are taken; only a further
// result stalls behind it.
module trie_insert_search_prefix_top import tisp_pkg::*; #(
	parameter int NODES    = NODES_DEF,
	parameter int ALPHABET = ALPHABET_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          cmd,
	input  logic [LETTER_W-1:0] letter,
	input  logic                letter_valid,
	input  logic                last,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                found,
	output logic                status
);

	ctrl_cmd_t ctl;
	ctrl_sts_t sts;

	tisp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	tisp_dpath #(
		.NODES    (NODES),
		.ALPHABET (ALPHABET)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.cmd          (cmd),
		.letter       (letter),
		.letter_valid (letter_valid),
		.last         (last),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.found        (found),
		.status       (status)
	);

endmodule
